FILE: sv/ltbc_pkg.sv
`default_nettype none
package ltbc_pkg;

    // table sizes and field widths
    localparam int LINK_ENTRIES = 16;
    localparam int DATA_ENTRIES = 32;
    localparam int TIME_BITS    = 32;
    localparam int TAG_BITS     = 32;

    localparam int MAX_ENTRIES = (DATA_ENTRIES > LINK_ENTRIES) ? DATA_ENTRIES : LINK_ENTRIES;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int LINK_AW     = (LINK_ENTRIES > 1) ? $clog2(LINK_ENTRIES) : 1;
    localparam int DATA_AW     = (DATA_ENTRIES > 1) ? $clog2(DATA_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    // all-ones tag marks an empty slot
    localparam logic [TAG_BITS-1:0]  TAG_INVALID = '1;
    localparam logic [TIME_BITS-1:0] RENORM_AT   = {{(TIME_BITS-1){1'b1}}, 1'b0};

    typedef enum logic [1:0] {
        OP_FIND   = 2'd0,
        OP_ALLOC  = 2'd1,
        OP_VICTIM = 2'd2,
        OP_INVAL  = 2'd3
    } ltbc_op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_NO_FREE   = 2'd2,
        ST_NO_VICTIM = 2'd3
    } ltbc_status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHK,
        S_SCAN,
        S_RN_RD_I,
        S_RN_GET_I,
        S_RN_CMP,
        S_RN_WR,
        S_RN_COPY,
        S_FIN
    } ltbc_state_t;

    typedef struct packed {
        logic load;
        logic cnt_clr;
        logic issue;
        logic rsel_i;
        logic scan_eval;
        logic i_clr;
        logic ti_load;
        logic rn_eval;
        logic rank_wr;
        logic copy_wr;
        logic clock_renorm;
        logic finish;
    } ltbc_cmd_t;

    typedef struct packed {
        ltbc_op_t op;
        logic     renorm_need;
        logic     cnt_done;
        logic     pend_last;
        logic     hit_now;
        logic     i_last;
        logic     out_free;
    } ltbc_stat_t;

endpackage
`default_nettype wire

FILE: sv/lru_tag_buffer_cache_unit.sv
`default_nettype none
// Two fully associative LRU tag tables (link area, 16 slots; data area, 32 slots) with
// per-slot access stamps and a running clock per table. One request is taken at a time.
// Find and allocate scan the table's tag memory one slot per cycle and stop at the first
// match, and the next request can be taken once the result is registered; a victim pick
// always scans to the first empty slot or to the end. Invalidate all gives its result
// without a scan. When the clock has reached all-ones minus one, a find or allocate first
// renormalizes the stamps: every slot is compared with every other through the single
// read port. The result sits in an output register, so the next request is accepted
// while it waits; a request that finishes while the previous result is still waiting
// holds until that result is taken.
module lru_tag_buffer_cache_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // tag
    input  wire logic [2:0]  s_tuser,   // req_type[1:0], table_sel[2]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // entry_index[4:0], old_valid[5], old_tag[37:6], zero
    output logic [1:0]       m_tuser    // status
);

    ltbc_pkg::ltbc_cmd_t  cmd;
    ltbc_pkg::ltbc_stat_t stat;
    logic [1:0]  status;
    logic [4:0]  entry_index;
    logic        old_valid;
    logic [31:0] old_tag;

    // sequencer
    ltbc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .stat(stat), .cmd(cmd)
    );

    // tables, scan and result
    ltbc_dpath u_dpath (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .req_type(s_tuser[1:0]), .table_sel(s_tuser[2]), .tag(s_tdata),
        .m_tready(m_tready), .out_valid(m_tvalid), .status(status),
        .entry_index(entry_index), .old_valid(old_valid), .old_tag(old_tag)
    );

    assign m_tdata = {2'b00, old_tag, old_valid, entry_index};
    assign m_tuser = status;

endmodule
`default_nettype wire

FILE: sv/ltbc_ram.sv
`default_nettype none
module ltbc_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: sv/ltbc_ctrl.sv
`default_nettype none
module ltbc_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire ltbc_pkg::ltbc_stat_t stat,
    output ltbc_pkg::ltbc_cmd_t      cmd
);

    ltbc_pkg::ltbc_state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ltbc_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ltbc_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ltbc_pkg::S_CHK;
                end
            end
            ltbc_pkg::S_CHK:
            begin
                if (stat.op == ltbc_pkg::OP_INVAL)
                begin
                    state_next = ltbc_pkg::S_FIN;
                end
                else if (stat.renorm_need && (stat.op == ltbc_pkg::OP_FIND ||
                                              stat.op == ltbc_pkg::OP_ALLOC))
                begin
                    cmd.i_clr  = 1'b1;
                    state_next = ltbc_pkg::S_RN_RD_I;
                end
                else
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = ltbc_pkg::S_SCAN;
                end
            end
            ltbc_pkg::S_SCAN:
            begin
                cmd.issue     = !stat.cnt_done;
                cmd.scan_eval = 1'b1;
                if (stat.hit_now || stat.pend_last)
                begin
                    state_next = ltbc_pkg::S_FIN;
                end
            end
            ltbc_pkg::S_RN_RD_I:
            begin
                cmd.rsel_i = 1'b1;
                state_next = ltbc_pkg::S_RN_GET_I;
            end
            ltbc_pkg::S_RN_GET_I:
            begin
                cmd.ti_load = 1'b1;
                cmd.cnt_clr = 1'b1;
                state_next  = ltbc_pkg::S_RN_CMP;
            end
            ltbc_pkg::S_RN_CMP:
            begin
                cmd.issue   = !stat.cnt_done;
                cmd.rn_eval = 1'b1;
                if (stat.pend_last)
                begin
                    state_next = ltbc_pkg::S_RN_WR;
                end
            end
            ltbc_pkg::S_RN_WR:
            begin
                cmd.rank_wr = 1'b1;
                if (stat.i_last)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = ltbc_pkg::S_RN_COPY;
                end
                else
                begin
                    state_next = ltbc_pkg::S_RN_RD_I;
                end
            end
            ltbc_pkg::S_RN_COPY:
            begin
                cmd.issue   = !stat.cnt_done;
                cmd.copy_wr = 1'b1;
                if (stat.pend_last)
                begin
                    cmd.clock_renorm = 1'b1;
                    cmd.cnt_clr      = 1'b1;
                    state_next       = ltbc_pkg::S_SCAN;
                end
            end
            ltbc_pkg::S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ltbc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ltbc_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: sv/ltbc_dpath.sv
`default_nettype none
module ltbc_dpath (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire ltbc_pkg::ltbc_cmd_t          cmd,
    output ltbc_pkg::ltbc_stat_t              stat,
    input  wire logic [1:0]                   req_type,
    input  wire logic                         table_sel,
    input  wire logic [31:0]                  tag,
    input  wire logic                         m_tready,
    output logic                              out_valid,
    output logic [1:0]                        status,
    output logic [4:0]                        entry_index,
    output logic                              old_valid,
    output logic [31:0]                       old_tag
);

    localparam int IW = ltbc_pkg::IDX_W;
    localparam int CW = ltbc_pkg::CNT_W;
    localparam int TW = ltbc_pkg::TIME_BITS;
    localparam int GW = ltbc_pkg::TAG_BITS;
    localparam int LA = ltbc_pkg::LINK_AW;
    localparam int DA = ltbc_pkg::DATA_AW;

    // request
    ltbc_pkg::ltbc_op_t op_reg;
    logic               sel_reg;
    logic [GW-1:0]      tag_reg;

    // table state kept in flip-flops
    logic [TW-1:0]                       link_clock_reg, data_clock_reg;
    logic [ltbc_pkg::LINK_ENTRIES-1:0]   link_tv_reg, link_mv_reg;
    logic [ltbc_pkg::DATA_ENTRIES-1:0]   data_tv_reg, data_mv_reg;

    // scan control
    logic [CW-1:0] cnt_reg;
    logic          pend_reg;
    logic [IW-1:0] ridx_reg;
    logic [IW-1:0] i_reg;
    logic [TW-1:0] ti_reg;
    logic [CW-1:0] rank_reg;

    // scan results
    logic          found_reg, have_old_reg;
    logic [IW-1:0] fidx_reg, bidx_reg;
    logic [TW-1:0] best_reg;
    logic [GW-1:0] btag_reg;

    // output register
    logic          out_valid_reg;
    logic [1:0]    status_reg;
    logic [4:0]    index_reg;
    logic          ovalid_reg;
    logic [31:0]   otag_reg;

    logic [CW-1:0] n_entries, n_last;
    logic [IW-1:0] raddr;
    logic [GW-1:0] ltag_q, dtag_q, tag_rd;
    logic [TW-1:0] ltime_q, dtime_q, time_rd, clock_cur;
    logic [IW-1:0] rank_q;
    logic          match;
    logic [IW-1:0] res_idx;
    logic          stamp_en, tag_we, time_we;
    logic [IW-1:0] time_waddr;
    logic [TW-1:0] time_wdata;
    logic [1:0]    res_status;
    logic [IW+4:0] res_index_ext;
    logic          res_ovalid;

    assign n_entries = sel_reg ? CW'(ltbc_pkg::DATA_ENTRIES) : CW'(ltbc_pkg::LINK_ENTRIES);
    assign n_last    = n_entries - CW'(1);
    assign raddr     = cmd.rsel_i ? i_reg : cnt_reg[IW-1:0];
    assign clock_cur = sel_reg ? data_clock_reg : link_clock_reg;

    // memories
    ltbc_ram #(.WIDTH(GW), .DEPTH(ltbc_pkg::LINK_ENTRIES)) u_link_tag (
        .clk(clk), .we(tag_we && !sel_reg), .waddr(res_idx[LA-1:0]), .wdata(tag_reg),
        .raddr(raddr[LA-1:0]), .rdata(ltag_q)
    );
    ltbc_ram #(.WIDTH(TW), .DEPTH(ltbc_pkg::LINK_ENTRIES)) u_link_time (
        .clk(clk), .we(time_we && !sel_reg), .waddr(time_waddr[LA-1:0]),
        .wdata(time_wdata), .raddr(raddr[LA-1:0]), .rdata(ltime_q)
    );
    ltbc_ram #(.WIDTH(GW), .DEPTH(ltbc_pkg::DATA_ENTRIES)) u_data_tag (
        .clk(clk), .we(tag_we && sel_reg), .waddr(res_idx[DA-1:0]), .wdata(tag_reg),
        .raddr(raddr[DA-1:0]), .rdata(dtag_q)
    );
    ltbc_ram #(.WIDTH(TW), .DEPTH(ltbc_pkg::DATA_ENTRIES)) u_data_time (
        .clk(clk), .we(time_we && sel_reg), .waddr(time_waddr[DA-1:0]),
        .wdata(time_wdata), .raddr(raddr[DA-1:0]), .rdata(dtime_q)
    );
    ltbc_ram #(.WIDTH(IW), .DEPTH(ltbc_pkg::MAX_ENTRIES)) u_rank (
        .clk(clk), .we(cmd.rank_wr), .waddr(i_reg), .wdata(rank_reg[IW-1:0]),
        .raddr(raddr), .rdata(rank_q)
    );

    // entries never written read as their reset values
    always_comb
    begin
        if (sel_reg)
        begin
            tag_rd  = data_tv_reg[ridx_reg[DA-1:0]] ? dtag_q : ltbc_pkg::TAG_INVALID;
            time_rd = data_mv_reg[ridx_reg[DA-1:0]] ? dtime_q : '0;
        end
        else
        begin
            tag_rd  = link_tv_reg[ridx_reg[LA-1:0]] ? ltag_q : ltbc_pkg::TAG_INVALID;
            time_rd = link_mv_reg[ridx_reg[LA-1:0]] ? ltime_q : '0;
        end
    end

    // slot match for the running scan
    always_comb
    begin
        case (op_reg)
            ltbc_pkg::OP_FIND:   match = (tag_rd == tag_reg) && (tag_reg != ltbc_pkg::TAG_INVALID);
            ltbc_pkg::OP_ALLOC:  match = (tag_rd == ltbc_pkg::TAG_INVALID);
            ltbc_pkg::OP_VICTIM: match = (tag_rd == ltbc_pkg::TAG_INVALID);
            default:             match = 1'b0;
        endcase
    end

    // result selection and write ports
    always_comb
    begin
        res_idx    = (op_reg == ltbc_pkg::OP_VICTIM && !found_reg) ? bidx_reg : fidx_reg;
        stamp_en   = cmd.finish && (op_reg != ltbc_pkg::OP_INVAL) &&
                     (found_reg || op_reg == ltbc_pkg::OP_VICTIM);
        tag_we     = stamp_en && (op_reg != ltbc_pkg::OP_FIND);
        time_we    = stamp_en || (cmd.copy_wr && pend_reg);
        time_waddr = stamp_en ? res_idx : ridx_reg;
        time_wdata = stamp_en ? clock_cur : TW'(rank_q);
        res_status = ltbc_pkg::ST_OK;
        case (op_reg)
            ltbc_pkg::OP_FIND:  if (!found_reg) res_status = ltbc_pkg::ST_NOT_FOUND;
            ltbc_pkg::OP_ALLOC: if (!found_reg) res_status = ltbc_pkg::ST_NO_FREE;
            default:            res_status = ltbc_pkg::ST_OK;
        endcase
        res_index_ext = '0;
        if (res_status == ltbc_pkg::ST_OK && op_reg != ltbc_pkg::OP_INVAL)
        begin
            res_index_ext = {5'b0, res_idx};
        end
        res_ovalid = (op_reg == ltbc_pkg::OP_VICTIM) && !found_reg;
    end

    // status towards the controller
    always_comb
    begin
        stat.op          = op_reg;
        stat.renorm_need = (clock_cur >= ltbc_pkg::RENORM_AT);
        stat.cnt_done    = (cnt_reg == n_entries);
        stat.pend_last   = pend_reg && (CW'(ridx_reg) == n_last);
        stat.hit_now     = pend_reg && match;
        stat.i_last      = (CW'(i_reg) == n_last);
        stat.out_free    = !out_valid_reg || m_tready;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            tag_reg <= tag[GW-1:0];
        end
        ridx_reg <= raddr;
        if (cmd.scan_eval && pend_reg && !match && op_reg == ltbc_pkg::OP_VICTIM &&
            (!have_old_reg || time_rd < best_reg))
        begin
            best_reg <= time_rd;
            bidx_reg <= ridx_reg;
            btag_reg <= tag_rd;
        end
        if (cmd.scan_eval && pend_reg && match)
        begin
            fidx_reg <= ridx_reg;
        end
        if (cmd.ti_load)
        begin
            ti_reg <= time_rd;
        end
        if (cmd.finish)
        begin
            status_reg <= res_status;
            index_reg  <= res_index_ext[4:0];
            ovalid_reg <= res_ovalid;
            otag_reg   <= res_ovalid ? 32'(btag_reg) : 32'd0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg         <= ltbc_pkg::OP_FIND;
            sel_reg        <= 1'b0;
            link_clock_reg <= '0;
            data_clock_reg <= '0;
            link_tv_reg    <= '0;
            link_mv_reg    <= '0;
            data_tv_reg    <= '0;
            data_mv_reg    <= '0;
            cnt_reg        <= '0;
            pend_reg       <= 1'b0;
            i_reg          <= '0;
            rank_reg       <= '0;
            found_reg      <= 1'b0;
            have_old_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                op_reg       <= ltbc_pkg::ltbc_op_t'(req_type);
                sel_reg      <= table_sel;
                found_reg    <= 1'b0;
                have_old_reg <= 1'b0;
            end
            // read address counter
            if (cmd.cnt_clr)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.issue)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            pend_reg <= cmd.issue;
            // scan bookkeeping
            if (cmd.scan_eval && pend_reg)
            begin
                if (match)
                begin
                    found_reg <= 1'b1;
                end
                else if (op_reg == ltbc_pkg::OP_VICTIM && (!have_old_reg || time_rd < best_reg))
                begin
                    have_old_reg <= 1'b1;
                end
            end
            // rank counting
            if (cmd.i_clr)
            begin
                i_reg <= '0;
            end
            else if (cmd.rank_wr)
            begin
                i_reg <= i_reg + IW'(1);
            end
            if (cmd.ti_load)
            begin
                rank_reg <= '0;
            end
            else if (cmd.rn_eval && pend_reg &&
                     (time_rd < ti_reg || (time_rd == ti_reg && ridx_reg < i_reg)))
            begin
                rank_reg <= rank_reg + CW'(1);
            end
            // valid bits follow the memory writes
            if (time_we)
            begin
                if (sel_reg)
                begin
                    data_mv_reg[time_waddr[DA-1:0]] <= 1'b1;
                end
                else
                begin
                    link_mv_reg[time_waddr[LA-1:0]] <= 1'b1;
                end
            end
            if (tag_we)
            begin
                if (sel_reg)
                begin
                    data_tv_reg[res_idx[DA-1:0]] <= 1'b1;
                end
                else
                begin
                    link_tv_reg[res_idx[LA-1:0]] <= 1'b1;
                end
            end
            // clocks and invalidation
            if (cmd.clock_renorm)
            begin
                if (sel_reg)
                begin
                    data_clock_reg <= TW'(n_entries);
                end
                else
                begin
                    link_clock_reg <= TW'(n_entries);
                end
            end
            if (stamp_en)
            begin
                if (sel_reg)
                begin
                    data_clock_reg <= data_clock_reg + TW'(1);
                end
                else
                begin
                    link_clock_reg <= link_clock_reg + TW'(1);
                end
            end
            if (cmd.finish && op_reg == ltbc_pkg::OP_INVAL)
            begin
                if (sel_reg)
                begin
                    data_tv_reg    <= '0;
                    data_clock_reg <= '0;
                end
                else
                begin
                    link_tv_reg    <= '0;
                    link_clock_reg <= '0;
                end
            end
            // output handshake
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign entry_index = index_reg;
    assign old_valid   = ovalid_reg;
    assign old_tag     = otag_reg;

endmodule
`default_nettype wire

FILE: sv/ltbc_checker.sv
`default_nettype none
module ltbc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    // one request at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a request is in progress");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a victim always exists
    a_no_victim_never: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser != ltbc_pkg::ST_NO_VICTIM)
        else $error("no-victim status produced");

    // failed requests report slot zero and no eviction
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != ltbc_pkg::ST_OK |-> m_tdata[5:0] == 6'd0)
        else $error("failed request carries an index or eviction");

endmodule

bind lru_tag_buffer_cache_unit ltbc_checker u_ltbc_checker (.*);
`default_nettype wire

FILE: sim/lru_tag_buffer_cache_unit_tb.sv
`default_nettype none
module lru_tag_buffer_cache_unit_tb;

    localparam int WATCHDOG_LIMIT = 20000;

    // one expected response
    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  idx;
        logic        ovalid;
        logic [31:0] otag;
    } lru_resp_t;

    // lru table predictor and response store
    class lru_scoreboard;
        logic [31:0] tags  [2][ltbc_pkg::MAX_ENTRIES];
        logic [31:0] times [2][ltbc_pkg::MAX_ENTRIES];
        logic [31:0] clocks [2];
        lru_resp_t   pending [$];
        int          errors;

        function new();
            errors = 0;
            for (int t = 0; t < 2; t++)
            begin
                clocks[t] = '0;
                for (int i = 0; i < ltbc_pkg::MAX_ENTRIES; i++)
                begin
                    tags[t][i]  = ltbc_pkg::TAG_INVALID;
                    times[t][i] = '0;
                end
            end
        endfunction

        function void rerank(int t, int n);
            logic [31:0] rank [ltbc_pkg::MAX_ENTRIES];
            if (clocks[t] < ltbc_pkg::RENORM_AT)
                return;
            for (int i = 0; i < n; i++)
            begin
                rank[i] = '0;
                for (int j = 0; j < n; j++)
                    if (times[t][j] < times[t][i] || (times[t][j] == times[t][i] && j < i))
                        rank[i]++;
            end
            for (int i = 0; i < n; i++)
                times[t][i] = rank[i];
            clocks[t] = 32'(n);
        endfunction

        function void note_request(ltbc_pkg::ltbc_op_t op, logic sel, logic [31:0] tag);
            lru_resp_t r;
            int t, n;
            bit got, have_old;
            logic [31:0] best;
            int k;
            t = sel;
            n = sel ? ltbc_pkg::DATA_ENTRIES : ltbc_pkg::LINK_ENTRIES;
            r = '0;
            got = 0;
            have_old = 0;
            best = 0;
            k = 0;
            case (op)
                ltbc_pkg::OP_FIND:
                begin
                    rerank(t, n);
                    if (tag != ltbc_pkg::TAG_INVALID)
                        for (int i = 0; i < n && !got; i++)
                            if (tags[t][i] == tag)
                            begin
                                got = 1;
                                k = i;
                            end
                    if (got)
                    begin
                        times[t][k] = clocks[t];
                        clocks[t]++;
                        r.idx = 5'(k);
                    end
                    else
                        r.status = ltbc_pkg::ST_NOT_FOUND;
                end
                ltbc_pkg::OP_ALLOC:
                begin
                    rerank(t, n);
                    for (int i = 0; i < n && !got; i++)
                        if (tags[t][i] == ltbc_pkg::TAG_INVALID)
                        begin
                            got = 1;
                            k = i;
                        end
                    if (got)
                    begin
                        tags[t][k]  = tag;
                        times[t][k] = clocks[t];
                        clocks[t]++;
                        r.idx = 5'(k);
                    end
                    else
                        r.status = ltbc_pkg::ST_NO_FREE;
                end
                ltbc_pkg::OP_VICTIM:
                begin
                    for (int i = 0; i < n && !got; i++)
                        if (tags[t][i] == ltbc_pkg::TAG_INVALID)
                        begin
                            got = 1;
                            k = i;
                        end
                        else if (!have_old || times[t][i] < best)
                        begin
                            have_old = 1;
                            best = times[t][i];
                            k = i;
                        end
                    if (tags[t][k] != ltbc_pkg::TAG_INVALID)
                    begin
                        r.ovalid = 1;
                        r.otag = tags[t][k];
                    end
                    tags[t][k]  = tag;
                    times[t][k] = clocks[t];
                    clocks[t]++;
                    r.idx = 5'(k);
                end
                default:
                begin
                    for (int i = 0; i < n; i++)
                        tags[t][i] = ltbc_pkg::TAG_INVALID;
                    clocks[t] = 0;
                end
            endcase
            pending.push_back(r);
        endfunction

        task report(string what, logic [31:0] got_v, logic [31:0] exp_v);
            $display("mismatch %s: got %h expected %h", what, got_v, exp_v);
            errors++;
        endtask

        task check_response(logic [1:0] st, logic [39:0] d);
            lru_resp_t e;
            if (pending.size() == 0)
            begin
                report("unexpected item", d[31:0], 0);
                return;
            end
            e = pending.pop_front();
            if (st != e.status)      report("status", st, e.status);
            if (d[4:0] != e.idx)     report("entry_index", d[4:0], e.idx);
            if (d[5] != e.ovalid)    report("old_valid", d[5], e.ovalid);
            if (d[37:6] != e.otag)   report("old_tag", d[37:6], e.otag);
            if (d[39:38] != 2'b00)   report("padding", d[39:38], 0);
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;

    lru_scoreboard sb;
    bit  calm;
    bit  hold_req;
    bit  hold_done;
    int  idle_cycles = 0;
    logic [31:0] recent [$];

    lru_tag_buffer_cache_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // send one request item, with random gaps before it
    task send_request(ltbc_pkg::ltbc_op_t op, logic sel, logic [31:0] tag);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 26)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= tag;
        s_tuser  <= {sel, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_request(op, sel, tag);
        if (tag != ltbc_pkg::TAG_INVALID)
            recent.push_back(tag);
        if (recent.size() > 40)
            void'(recent.pop_front());
    endtask

    function automatic logic [31:0] pick_tag();
        int c;
        c = $urandom_range(9);
        if (c < 5 && recent.size() > 0)
            return recent[$urandom_range(recent.size() - 1)];
        if (c == 5)
            return ltbc_pkg::TAG_INVALID;
        if (c == 6)
            return 32'hFFFF_FFFE;
        if (c == 7)
            return $urandom_range(7);
        return $urandom;
    endfunction

    // receiver: random stalls, one long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                m_tready <= 1'b0;
                repeat (400) @(negedge clk);
                hold_done = 1'b1;
            end
            m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 26);
        end
    end

    // result checking and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_response(m_tuser, m_tdata);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > WATCHDOG_LIMIT)
            begin
                $display("lru_tag_buffer_cache_unit test failed");
                $finish;
            end
        end
    end

    // stimulus
    initial
    begin
        int r;
        logic sel;
        sb = new();
        calm = 0;
        hold_req = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty tables, fill link table, overflow, victims, invalid tag
        send_request(ltbc_pkg::OP_FIND, 1'b0, 32'h0);
        send_request(ltbc_pkg::OP_VICTIM, 1'b1, 32'h0);
        send_request(ltbc_pkg::OP_FIND, 1'b1, 32'h0);
        send_request(ltbc_pkg::OP_FIND, 1'b1, ltbc_pkg::TAG_INVALID);
        for (int i = 0; i < ltbc_pkg::LINK_ENTRIES; i++)
            send_request(ltbc_pkg::OP_ALLOC, 1'b0, 32'h100 + i);
        send_request(ltbc_pkg::OP_ALLOC, 1'b0, 32'hFFFF_FFFE);
        send_request(ltbc_pkg::OP_FIND, 1'b0, 32'h105);
        send_request(ltbc_pkg::OP_VICTIM, 1'b0, ltbc_pkg::TAG_INVALID);
        send_request(ltbc_pkg::OP_VICTIM, 1'b0, 32'hA5A5_5A5A);
        send_request(ltbc_pkg::OP_INVAL, 1'b0, 32'h0);
        send_request(ltbc_pkg::OP_INVAL, 1'b1, 32'hFFFF_FFFF);

        // random; long receiver hold-off early on
        for (int n = 0; n < 450; n++)
        begin
            calm = (n >= 150 && n < 230);
            if (n == 40)
                hold_req = 1;
            sel = $urandom_range(1);
            r = $urandom_range(99);
            if (r < 40)
                send_request(ltbc_pkg::OP_FIND, sel, pick_tag());
            else if (r < 65)
                send_request(ltbc_pkg::OP_ALLOC, sel, pick_tag());
            else if (r < 95)
                send_request(ltbc_pkg::OP_VICTIM, sel, pick_tag());
            else
                send_request(ltbc_pkg::OP_INVAL, sel, pick_tag());
        end
        @(negedge clk);
        s_tvalid <= 1'b0;
        calm = 0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (sb.errors == 0)
            $display("lru_tag_buffer_cache_unit test passed");
        else
            $display("lru_tag_buffer_cache_unit test failed");
        $finish;
    end
endmodule
`default_nettype wire
